FILE: hw/rtl/nms_pkg.sv
// shared types and constants of the box suppression block
`default_nettype none
package nms_pkg;

  // overlap threshold register
  localparam int unsigned THR_BITS  = 9;
  localparam logic [THR_BITS-1:0] THR_RESET = 9'd77;

  // threshold is in 1/256 units
  localparam int unsigned FRAC_BITS = 8;

  // flags of one result
  typedef struct packed {
    logic keep;
    logic overflow;
    logic frame_done;
  } res_flags_t;

endpackage
`default_nettype wire

FILE: hw/rtl/nms_ram.sv
// generic single write port ram with registered read
`default_nettype none
module nms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: hw/rtl/nms_front.sv
// front stage: takes boxes, numbers them in the frame and works out their area
`default_nettype none
module nms_front #(
  parameter int COORD_BITS = 13,
  parameter int MAX_BOXES  = 8192,
  parameter int ENTRY_W    = 4 * 13 + 2 * 13 + 13 + 1
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic signed [COORD_BITS-1:0] left,
  input  wire logic signed [COORD_BITS-1:0] top,
  input  wire logic signed [COORD_BITS-1:0] right,
  input  wire logic signed [COORD_BITS-1:0] bottom,
  input  wire logic                         frame_end,
  output logic                              push_valid,
  input  wire logic                         push_full,
  output logic [ENTRY_W-1:0]                push_data
);

  localparam int IW = $clog2(MAX_BOXES);
  localparam int CW = COORD_BITS;

  logic                 f_valid;
  logic signed [CW-1:0] f_left, f_top, f_right, f_bottom;
  logic [CW-1:0]        f_w, f_h;
  logic [IW-1:0]        f_index;
  logic                 f_last;
  logic [IW-1:0]        position;
  logic                 accept;
  logic signed [CW:0]   dx, dy;
  logic [2*CW-1:0]      area;

  assign in_stall = f_valid && push_full;
  assign accept   = in_valid && !in_stall;

  assign dx = {right[CW-1], right} - {left[CW-1], left};
  assign dy = {bottom[CW-1], bottom} - {top[CW-1], top};

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid  <= 1'b0;
      position <= '0;
    end else begin
      if (accept) begin
        f_valid <= 1'b1;
        if (frame_end || position == IW'(MAX_BOXES - 1)) begin
          position <= '0;
        end else begin
          position <= position + 1'b1;
        end
      end else if (!push_full) begin
        f_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_left   <= left;
      f_top    <= top;
      f_right  <= right;
      f_bottom <= bottom;
      f_index  <= position;
      f_last   <= frame_end;
      // inverted or empty box has no width
      f_w      <= (dx > 0) ? dx[CW-1:0] : '0;
      f_h      <= (dy > 0) ? dy[CW-1:0] : '0;
    end
  end

  assign area       = f_w * f_h;
  assign push_valid = f_valid;
  assign push_data  = {f_last, f_index, area, f_bottom, f_right, f_top, f_left};

endmodule
`default_nettype wire

FILE: hw/rtl/nms_queue.sv
// two entry queue between front and back
`default_nettype none
module nms_queue #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push_valid,
  output logic                  push_full,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  pop_valid,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data
);

  logic [WIDTH-1:0] entries [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign push_full = (count == 2'd2);
  assign pop_valid = (count != 2'd0);
  assign pop_data  = entries[rd_ptr];
  assign do_push   = push_valid && !push_full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/nms_back.sv
// back stage: scans the kept boxes, decides keep or suppress, updates the store
`default_nettype none
module nms_back #(
  parameter int COORD_BITS = 13,
  parameter int MAX_KEPT   = 64,
  parameter int MAX_BOXES  = 8192,
  parameter int ENTRY_W    = 4 * 13 + 2 * 13 + 13 + 1
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic [nms_pkg::THR_BITS-1:0]   iou_threshold,
  input  wire logic                           pop_valid,
  output logic                                pop,
  input  wire logic [ENTRY_W-1:0]             pop_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output nms_pkg::res_flags_t                 out_flags,
  output logic [$clog2(MAX_BOXES)-1:0]        out_index
);

  import nms_pkg::*;

  localparam int CW     = COORD_BITS;
  localparam int IW     = $clog2(MAX_BOXES);
  localparam int AW     = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int KW     = $clog2(MAX_KEPT + 1);
  localparam int AREA_W = 2 * CW;
  localparam int UNI_W  = AREA_W + 1;
  localparam int PROD_W = UNI_W + THR_BITS;
  localparam int STORE_W = 6 * CW;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;

  logic [1:0]           state;
  logic [KW-1:0]        kept_count;
  logic [KW-1:0]        scan_idx;
  logic                 suppressed;

  // current box
  logic signed [CW-1:0] c_left, c_top, c_right, c_bottom;
  logic [AREA_W-1:0]    c_area;
  logic [IW-1:0]        c_index;
  logic                 c_last;

  // compare pipeline
  logic                 issue;
  logic                 rd_valid, va, vb, vc, vd;
  logic [STORE_W-1:0]   rdata;
  logic [CW-1:0]        a_w, a_h;
  logic [AREA_W-1:0]    a_area;
  logic [AREA_W-1:0]    b_inter, b_area;
  logic [AREA_W-1:0]    c_inter;
  logic [UNI_W-1:0]     c_uni;
  logic [AREA_W-1:0]    d_inter;
  logic [PROD_W-1:0]    d_prod;

  logic signed [CW-1:0] k_left, k_top, k_right, k_bottom;
  logic [AREA_W-1:0]    k_area;
  logic signed [CW-1:0] ix0, iy0, ix1, iy1;
  logic signed [CW:0]   idx, idy;
  logic [PROD_W-1:0]    lhs;

  logic                 out_free;
  logic                 keep_now;
  logic                 scan_done;
  logic                 we;
  logic [STORE_W-1:0]   wdata;

  nms_ram #(
    .WIDTH (STORE_W),
    .DEPTH (MAX_KEPT)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (kept_count[AW-1:0]),
    .wdata (wdata),
    .raddr (scan_idx[AW-1:0]),
    .rdata (rdata)
  );

  assign pop       = (state == S_IDLE);
  assign issue     = (state == S_SCAN) && (scan_idx < kept_count);
  assign scan_done = (state == S_SCAN) && (scan_idx == kept_count)
                     && !rd_valid && !va && !vb && !vc && !vd;
  assign out_free  = !out_valid || !out_stall;
  assign keep_now  = !suppressed && (kept_count < KW'(MAX_KEPT));
  assign we        = (state == S_DECIDE) && out_free && keep_now;
  assign wdata     = {c_area, c_bottom, c_right, c_top, c_left};

  // overlap of the current box with the stored one
  assign k_left   = $signed(rdata[CW-1:0]);
  assign k_top    = $signed(rdata[2*CW-1:CW]);
  assign k_right  = $signed(rdata[3*CW-1:2*CW]);
  assign k_bottom = $signed(rdata[4*CW-1:3*CW]);
  assign k_area   = rdata[6*CW-1:4*CW];
  assign ix0 = (c_left > k_left) ? c_left : k_left;
  assign iy0 = (c_top > k_top) ? c_top : k_top;
  assign ix1 = (c_right < k_right) ? c_right : k_right;
  assign iy1 = (c_bottom < k_bottom) ? c_bottom : k_bottom;
  assign idx = {ix1[CW-1], ix1} - {ix0[CW-1], ix0};
  assign idy = {iy1[CW-1], iy1} - {iy0[CW-1], iy0};
  assign lhs = PROD_W'({d_inter, {FRAC_BITS{1'b0}}});

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      kept_count <= '0;
      scan_idx   <= '0;
      suppressed <= 1'b0;
      rd_valid   <= 1'b0;
      va         <= 1'b0;
      vb         <= 1'b0;
      vc         <= 1'b0;
      vd         <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      rd_valid <= issue;
      va       <= rd_valid;
      vb       <= va;
      vc       <= vb;
      vd       <= vc;
      if (vd && (lhs > d_prod)) begin
        suppressed <= 1'b1;
      end
      if ((state == S_DECIDE) && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pop_valid) begin
            scan_idx   <= '0;
            suppressed <= 1'b0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (issue) begin
            scan_idx <= scan_idx + 1'b1;
          end
          if (scan_done) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (out_free) begin
            if (c_last) begin
              kept_count <= '0;
            end else if (keep_now) begin
              kept_count <= kept_count + 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop && pop_valid) begin
      c_left   <= $signed(pop_data[CW-1:0]);
      c_top    <= $signed(pop_data[2*CW-1:CW]);
      c_right  <= $signed(pop_data[3*CW-1:2*CW]);
      c_bottom <= $signed(pop_data[4*CW-1:3*CW]);
      c_area   <= pop_data[6*CW-1:4*CW];
      c_index  <= pop_data[6*CW+IW-1:6*CW];
      c_last   <= pop_data[6*CW+IW];
    end
    a_w     <= (idx > 0) ? idx[CW-1:0] : '0;
    a_h     <= (idy > 0) ? idy[CW-1:0] : '0;
    a_area  <= k_area;
    b_inter <= a_w * a_h;
    b_area  <= a_area;
    // inter never exceeds either area, so the union stays non-negative
    c_uni   <= UNI_W'(c_area) + UNI_W'(b_area) - UNI_W'(b_inter);
    c_inter <= b_inter;
    d_prod  <= PROD_W'(iou_threshold) * PROD_W'(c_uni);
    d_inter <= c_inter;
    if ((state == S_DECIDE) && out_free) begin
      out_flags.keep       <= keep_now;
      out_flags.overflow   <= !suppressed && !keep_now;
      out_flags.frame_done <= c_last;
      out_index            <= c_index;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/greedy_box_nms.sv
// top level of the greedy box suppression block
//
//   channel  | signals                                   | flow
//   ---------+-------------------------------------------+------------------
//   in       | in_valid/in_stall, left top right bottom,  | boxes in score order
//            | frame_end                                  |
//   out      | out_valid/out_stall, keep box_index        | one result per box
//            | overflow frame_done                        |
//   cfg      | cfg_valid/cfg_ready, cfg_data              | iou_threshold write
//
// in the back stage a box is compared with every kept box of the frame: one stored box is
// read from the kept ram and compared per cycle, then the compare pipeline drains. the front
// stage and a two entry queue take up to three boxes ahead of the back.
// rst is synchronous: kept list and frame position clear, threshold returns to 77.
// a stalled result holds the back stage; a full queue stalls the input.
`default_nettype none
module greedy_box_nms #(
  parameter int MAX_KEPT   = 64,
  parameter int COORD_BITS = 13,
  parameter int MAX_BOXES  = 8192
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic signed [COORD_BITS-1:0]     left,
  input  wire logic signed [COORD_BITS-1:0]     top,
  input  wire logic signed [COORD_BITS-1:0]     right,
  input  wire logic signed [COORD_BITS-1:0]     bottom,
  input  wire logic                             frame_end,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic                                  keep,
  output logic [$clog2(MAX_BOXES)-1:0]          box_index,
  output logic                                  overflow,
  output logic                                  frame_done,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [nms_pkg::THR_BITS-1:0]     cfg_data
);

  import nms_pkg::*;

  localparam int ENTRY_W = 6 * COORD_BITS + $clog2(MAX_BOXES) + 1;

  logic [THR_BITS-1:0] iou_threshold;
  logic                push_valid;
  logic                push_full;
  logic [ENTRY_W-1:0]  push_data;
  logic                pop_valid;
  logic                pop;
  logic [ENTRY_W-1:0]  pop_data;
  res_flags_t          flags;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      iou_threshold <= THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      iou_threshold <= cfg_data;
    end
  end

  nms_front #(
    .COORD_BITS (COORD_BITS),
    .MAX_BOXES  (MAX_BOXES),
    .ENTRY_W    (ENTRY_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .left       (left),
    .top        (top),
    .right      (right),
    .bottom     (bottom),
    .frame_end  (frame_end),
    .push_valid (push_valid),
    .push_full  (push_full),
    .push_data  (push_data)
  );

  nms_queue #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_full  (push_full),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_data   (pop_data)
  );

  nms_back #(
    .COORD_BITS (COORD_BITS),
    .MAX_KEPT   (MAX_KEPT),
    .MAX_BOXES  (MAX_BOXES),
    .ENTRY_W    (ENTRY_W)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .iou_threshold (iou_threshold),
    .pop_valid     (pop_valid),
    .pop           (pop),
    .pop_data      (pop_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_flags     (flags),
    .out_index     (box_index)
  );

  assign keep       = flags.keep;
  assign overflow   = flags.overflow;
  assign frame_done = flags.frame_done;

endmodule
`default_nettype wire

FILE: verif/greedy_box_nms_tb.sv
`timescale 1ns / 100ps
// greedy_box_nms testbench: directed and random box frames checked against a local iou predictor
module greedy_box_nms_tb;

  localparam int KEPT_DEPTH   = 64;
  localparam int COORD_W      = 13;
  localparam int FRAME_LEN    = 8192;
  localparam int IDX_W        = $clog2(FRAME_LEN);
  localparam int QUIET_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 200;
  localparam int PHASE_BOXES  = 105;

  typedef enum int {FRAME_GRID, FRAME_CLUSTER, FRAME_NOISE} frame_kind_e;

  typedef struct {
    int x0;
    int y0;
    int x1;
    int y1;
    bit last;
  } box_req_t;

  typedef struct packed {
    logic             keep;
    logic [IDX_W-1:0] index;
    logic             overflow;
    logic             done;
  } verdict_t;

  logic                          clk;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic signed [COORD_W-1:0]     left = '0;
  logic signed [COORD_W-1:0]     top = '0;
  logic signed [COORD_W-1:0]     right = '0;
  logic signed [COORD_W-1:0]     bottom = '0;
  logic                          frame_end = 1'b0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic                          keep;
  logic [IDX_W-1:0]              box_index;
  logic                          overflow;
  logic                          frame_done;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [nms_pkg::THR_BITS-1:0]  cfg_data = '0;

  box_req_t    pending_boxes[$];
  verdict_t    verdicts_due[$];
  box_req_t    kept_store[KEPT_DEPTH];
  int          kept_total = 0;
  int          frame_pos = 0;
  int unsigned iou_limit = nms_pkg::THR_RESET;
  int          boxes_queued = 0;
  int          boxes_shown = 0;
  int          boxes_taken = 0;
  int          in_gap = 0;
  int          out_gap = 0;
  int          mismatches = 0;
  int          quiet_cycles = 0;
  bit          calm = 1'b0;

  greedy_box_nms #(
    .MAX_KEPT   (KEPT_DEPTH),
    .COORD_BITS (COORD_W),
    .MAX_BOXES  (FRAME_LEN)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .left       (left),
    .top        (top),
    .right      (right),
    .bottom     (bottom),
    .frame_end  (frame_end),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .keep       (keep),
    .box_index  (box_index),
    .overflow   (overflow),
    .frame_done (frame_done),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic longint span(input longint lo, input longint hi);
    return (hi > lo) ? hi - lo : 64'sd0;
  endfunction

  function automatic longint box_area(input box_req_t b);
    return span(b.x0, b.x1) * span(b.y0, b.y1);
  endfunction

  // greedy suppression against the boxes kept so far in this frame
  function automatic verdict_t nms_decide(input box_req_t cur);
    longint   cur_area;
    longint   inter;
    longint   uni;
    box_req_t k;
    bit       hit;
    verdict_t v;
    hit = 1'b0;
    cur_area = box_area(cur);
    for (int j = 0; j < kept_total; j++) begin
      k = kept_store[j];
      inter = span((cur.x0 > k.x0) ? cur.x0 : k.x0, (cur.x1 < k.x1) ? cur.x1 : k.x1) *
              span((cur.y0 > k.y0) ? cur.y0 : k.y0, (cur.y1 < k.y1) ? cur.y1 : k.y1);
      uni = cur_area + box_area(k) - inter;
      if (inter * 256 > longint'(iou_limit) * uni) hit = 1'b1;
    end
    v.keep = 1'b0;
    v.overflow = 1'b0;
    if (!hit) begin
      if (kept_total < KEPT_DEPTH) begin
        kept_store[kept_total] = cur;
        kept_total++;
        v.keep = 1'b1;
      end else begin
        v.overflow = 1'b1;
      end
    end
    v.index = IDX_W'(frame_pos);
    v.done = cur.last;
    if (cur.last) begin
      kept_total = 0;
      frame_pos = 0;
    end else begin
      frame_pos = (frame_pos + 1) % FRAME_LEN;
    end
    return v;
  endfunction

  function automatic int clip(input int v);
    return (v < -4096) ? -4096 : (v > 4095) ? 4095 : v;
  endfunction

  function automatic int any_coord();
    case ($urandom_range(0, 7))
      0: return -4096;
      1: return 4095;
      default: return int'($urandom_range(0, 8191)) - 4096;
    endcase
  endfunction

  task automatic queue_box(input int x0, input int y0, input int x1, input int y1,
                           input bit last);
    box_req_t b;
    b.x0 = x0;
    b.y0 = y0;
    b.x1 = x1;
    b.y1 = y1;
    b.last = last;
    pending_boxes.insert(pending_boxes.size(), b);
    boxes_queued++;
  endtask

  // one frame of boxes; grid frames mostly fill the store, clusters overlap near the limit
  task automatic queue_random_frame(input frame_kind_e kind, inout int count);
    int n;
    int cx;
    int cy;
    int w;
    int h;
    int x0;
    int y0;
    int bw;
    int bh;
    bit last;
    case (kind)
      FRAME_GRID:    n = $urandom_range(30, 80);
      FRAME_CLUSTER: n = $urandom_range(1, 30);
      default:       n = $urandom_range(1, 20);
    endcase
    cx = int'($urandom_range(0, 6000)) - 3000;
    cy = int'($urandom_range(0, 6000)) - 3000;
    w = $urandom_range(4, 400);
    h = $urandom_range(4, 400);
    for (int i = 0; i < n; i++) begin
      last = (i == n - 1);
      case (kind)
        FRAME_GRID: begin
          x0 = any_coord();
          y0 = any_coord();
          queue_box(x0, y0, clip(x0 + int'($urandom_range(0, 40))),
                    clip(y0 + int'($urandom_range(0, 40))), last);
        end
        FRAME_CLUSTER: begin
          if ($urandom_range(0, 4) == 0) begin
            cx = int'($urandom_range(0, 6000)) - 3000;
            cy = int'($urandom_range(0, 6000)) - 3000;
          end
          x0 = cx + int'($urandom_range(0, w / 2)) - w / 4;
          y0 = cy + int'($urandom_range(0, h / 2)) - h / 4;
          bw = w + int'($urandom_range(0, w / 4)) - w / 8;
          bh = h + int'($urandom_range(0, h / 4)) - h / 8;
          queue_box(clip(x0), clip(y0), clip(x0 + bw), clip(y0 + bh), last);
        end
        default: begin
          // broken frames: the end mark may come anywhere
          if ($urandom_range(0, 7) == 0) last = 1'b1;
          queue_box(any_coord(), any_coord(), any_coord(), any_coord(), last);
        end
      endcase
    end
    count += n;
  endtask

  task automatic wait_idle();
    while (pending_boxes.size() != 0 || boxes_taken != boxes_queued ||
           verdicts_due.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_threshold(input int unsigned v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= nms_pkg::THR_BITS'(v);
    do @(posedge clk); while (cfg_ready !== 1'b1);
    iou_limit = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(negedge clk) begin : drive_boxes
    box_req_t nxt;
    logic     show;
    show = in_valid;
    if (rst) begin
      show = 1'b0;
    end else if (!(in_valid && boxes_taken != boxes_shown)) begin
      show = 1'b0;
      if (calm) in_gap = 0;
      if (in_gap > 0) begin
        in_gap--;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        in_gap = $urandom_range(1, 19) - 1;
      end else if (pending_boxes.size() != 0) begin
        nxt = pending_boxes.pop_front();
        left <= COORD_W'(nxt.x0);
        top <= COORD_W'(nxt.y0);
        right <= COORD_W'(nxt.x1);
        bottom <= COORD_W'(nxt.y1);
        frame_end <= nxt.last;
        show = 1'b1;
        boxes_shown++;
      end
    end
    in_valid <= show;
  end

  always @(negedge clk) begin : drive_stall
    logic hold;
    if (calm) out_gap = 0;
    if (out_gap > 0) begin
      out_gap--;
      hold = 1'b1;
    end else if (!calm && $urandom_range(0, 11) == 0) begin
      out_gap = $urandom_range(1, 19) - 1;
      hold = 1'b1;
    end else begin
      hold = 1'b0;
    end
    out_stall <= hold;
  end

  always @(posedge clk) begin : take_boxes
    box_req_t seen;
    verdict_t due;
    if (!rst && in_valid && !in_stall) begin
      seen.x0 = left;
      seen.y0 = top;
      seen.x1 = right;
      seen.y1 = bottom;
      seen.last = frame_end;
      due = nms_decide(seen);
      verdicts_due.insert(verdicts_due.size(), due);
      boxes_taken <= boxes_taken + 1;
    end
  end

  always @(posedge clk) begin : check_results
    verdict_t got;
    verdict_t want;
    if (!rst && out_valid && !out_stall) begin
      got = {keep, box_index, overflow, frame_done};
      if (verdicts_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result with no box pending: keep %0b index %0d overflow %0b done %0b",
                   got.keep, got.index, got.overflow, got.done);
      end else begin
        want = verdicts_due.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected keep %0b index %0d overflow %0b done %0b, %s",
                     want.keep, want.index, want.overflow, want.done,
                     $sformatf("got keep %0b index %0d overflow %0b done %0b",
                               got.keep, got.index, got.overflow, got.done));
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : run_test
    frame_kind_e kind;
    int          phase_items;
    int unsigned pick;

    // reset threshold: overlaps, extremes, inverted and empty boxes
    queue_box(0, 0, 100, 100, 1'b0);
    queue_box(0, 0, 100, 100, 1'b0);
    queue_box(50, 0, 150, 100, 1'b0);
    queue_box(60, 0, 160, 100, 1'b0);
    queue_box(-4096, -4096, 4095, 4095, 1'b0);
    queue_box(100, 100, 0, 0, 1'b0);
    queue_box(100, 100, 0, 0, 1'b0);
    queue_box(10, 10, 10, 50, 1'b0);
    queue_box(4095, 4095, -4096, -4096, 1'b0);
    queue_box(-4096, -4096, -4095, -4095, 1'b0);
    queue_box(4094, 4094, 4095, 4095, 1'b1);
    queue_box(0, 0, 100, 100, 1'b1);
    queue_box(-1, -1, 1, 1, 1'b0);
    queue_box(-1, -1, 1, 1, 1'b0);
    queue_box(-2, -2, 2, 2, 1'b1);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    wait_idle();

    for (int p = 0; p < 9; p++) begin
      case (p)
        0: pick = 0;
        1: pick = 256;
        2: pick = 1;
        3: pick = 255;
        4: pick = 128;
        5: pick = nms_pkg::THR_RESET;
        default: pick = $urandom_range(0, 256);
      endcase
      write_threshold(pick);
      if (p == 8) calm = 1'b1;
      phase_items = 0;
      while (phase_items < PHASE_BOXES) begin
        pick = $urandom_range(0, 19);
        if (pick < 8) kind = FRAME_CLUSTER;
        else if (pick < 15) kind = FRAME_GRID;
        else kind = FRAME_NOISE;
        queue_random_frame(kind, phase_items);
      end
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && verdicts_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: greedy_box_nms.f
hw/rtl/nms_pkg.sv
hw/rtl/nms_ram.sv
hw/rtl/nms_front.sv
hw/rtl/nms_queue.sv
hw/rtl/nms_back.sv
hw/rtl/greedy_box_nms.sv
verif/greedy_box_nms_tb.sv
